### sv/rlcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rlcf_pkg;

  localparam int RGB_W      = 8;   // one channel drive level
  localparam int IDX_W      = 3;   // color index
  localparam int EVENT_W    = 32;  // event word
  localparam int NUM_COLORS = 8;
  localparam int QUOT_W     = 10;  // signed per-step increment
  localparam int ACC_W      = 18;  // signed channel accumulator
  localparam int STEP_OUT_W = 5;   // fade_step port

  localparam int DEF_FADE_DIVISOR = 20;
  localparam int DEF_FIRST_STEP   = 10;

  // Channel order inside an rgb_t.
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int NUM_CH   = 3;

  typedef enum logic [IDX_W-1:0] {
    COLOR_BLACK  = 3'd0,
    COLOR_RED    = 3'd1,
    COLOR_GREEN  = 3'd2,
    COLOR_BLUE   = 3'd3,
    COLOR_PURPLE = 3'd4,
    COLOR_CYAN   = 3'd5,
    COLOR_YELLOW = 3'd6,
    COLOR_WHITE  = 3'd7
  } color_e;

  typedef logic [NUM_CH-1:0][RGB_W-1:0] rgb_t;

  // One fade run handed from the decoder to the fade engine.
  typedef struct packed {
    rgb_t                             start;
    logic [NUM_CH-1:0][QUOT_W-1:0]    quot;
    rgb_t                             target;
  } job_t;

  function automatic rgb_t mk_rgb(logic [RGB_W-1:0] r, logic [RGB_W-1:0] g,
                                  logic [RGB_W-1:0] b);
    rgb_t c;
    c[CH_RED]   = r;
    c[CH_GREEN] = g;
    c[CH_BLUE]  = b;
    return c;
  endfunction

  function automatic rgb_t palette(logic [IDX_W-1:0] idx);
    rgb_t c;
    case (idx)
      COLOR_BLACK:  c = mk_rgb(8'd0,   8'd0,  8'd0);
      COLOR_RED:    c = mk_rgb(8'd255, 8'd0,  8'd0);
      COLOR_GREEN:  c = mk_rgb(8'd0,   8'd80, 8'd0);
      COLOR_BLUE:   c = mk_rgb(8'd0,   8'd0,  8'd255);
      COLOR_PURPLE: c = mk_rgb(8'd255, 8'd0,  8'd80);
      COLOR_CYAN:   c = mk_rgb(8'd0,   8'd80, 8'd100);
      COLOR_YELLOW: c = mk_rgb(8'd255, 8'd60, 8'd0);
      COLOR_WHITE:  c = mk_rgb(8'd255, 8'd80, 8'd100);
      default:      c = mk_rgb(8'd0,   8'd0,  8'd0);
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### sv/rlcf_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module rlcf_decode #(
  parameter int FADE_DIVISOR = rlcf_pkg::DEF_FADE_DIVISOR
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [rlcf_pkg::EVENT_W-1:0]  event_bits_i,
  output logic                               job_valid_o,
  input  wire logic                          job_take_i,
  output rlcf_pkg::job_t                     job_o
);

  // Reciprocal of the divisor; floor(x * RECIP >> RECIP_SH) is exact while
  // x * FADE_DIVISOR < 2**RECIP_SH, which holds for x, divisor up to 255.
  localparam int RECIP_SH = 16;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int PROD_W   = rlcf_pkg::RGB_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((2 ** RECIP_SH + FADE_DIVISOR - 1) / FADE_DIVISOR);

  logic                             ev_valid_q;
  logic [rlcf_pkg::EVENT_W-1:0]     ev_q;
  logic [rlcf_pkg::IDX_W-1:0]       color_q;
  logic                             job_valid_q;
  rlcf_pkg::job_t                   job_q, job_d;

  logic [rlcf_pkg::IDX_W-1:0]       top;
  logic                             top_ok;
  logic                             hit;
  logic                             pass;
  rlcf_pkg::rgb_t                   src_rgb, dst_rgb;
  logic signed [rlcf_pkg::QUOT_W-1:0] diff [rlcf_pkg::NUM_CH];
  logic [rlcf_pkg::NUM_CH-1:0]                        neg;
  logic [rlcf_pkg::NUM_CH-1:0][rlcf_pkg::RGB_W-1:0]   mag;
  logic [rlcf_pkg::NUM_CH-1:0][PROD_W-1:0]            prod;
  logic [rlcf_pkg::NUM_CH-1:0][rlcf_pkg::QUOT_W-1:0]  q_mag;

  // Highest set bit; only the low eight bits can name a color.
  always_comb begin
    top = '0;
    for (int i = 0; i < rlcf_pkg::NUM_COLORS; i++) begin
      if (ev_q[i]) begin
        top = rlcf_pkg::IDX_W'(i);
      end
    end
  end

  assign top_ok = (ev_q[rlcf_pkg::EVENT_W-1:rlcf_pkg::NUM_COLORS] == '0) &&
                  (ev_q[rlcf_pkg::NUM_COLORS-1:0] != '0);
  assign hit    = ev_valid_q && top_ok && (top != color_q);

  // Drop events that start no run; hold a run until the job slot frees.
  assign pass       = !hit || !job_valid_q || job_take_i;
  assign in_stall_o = ev_valid_q && !pass;

  assign src_rgb = rlcf_pkg::palette(color_q);
  assign dst_rgb = rlcf_pkg::palette(top);

  // Divide the magnitude, then restore the sign: truncates toward zero.
  always_comb begin
    job_d.start  = src_rgb;
    job_d.target = dst_rgb;
    for (int c = 0; c < rlcf_pkg::NUM_CH; c++) begin
      diff[c]  = $signed({2'b00, dst_rgb[c]}) - $signed({2'b00, src_rgb[c]});
      neg[c]   = diff[c][rlcf_pkg::QUOT_W-1];
      mag[c]   = neg[c] ? rlcf_pkg::RGB_W'(-diff[c]) : rlcf_pkg::RGB_W'(diff[c]);
      prod[c]  = PROD_W'(mag[c]) * RECIP;
      q_mag[c] = rlcf_pkg::QUOT_W'(prod[c][RECIP_SH +: rlcf_pkg::RGB_W]);
      job_d.quot[c] = neg[c] ? (rlcf_pkg::QUOT_W'(0) - q_mag[c]) : q_mag[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q  <= 1'b0;
      job_valid_q <= 1'b0;
      color_q     <= rlcf_pkg::COLOR_BLACK;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        ev_valid_q <= 1'b1;
      end else if (pass) begin
        ev_valid_q <= 1'b0;
      end
      if (hit && pass) begin
        job_valid_q <= 1'b1;
        color_q     <= top;
      end else if (job_take_i) begin
        job_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      ev_q <= event_bits_i;
    end
    if (hit && pass) begin
      job_q <= job_d;
    end
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

endmodule

`default_nettype wire

### sv/rlcf_fade.sv
`timescale 1ns / 1ps
`default_nettype none

module rlcf_fade #(
  parameter int FADE_DIVISOR = rlcf_pkg::DEF_FADE_DIVISOR,
  parameter int FIRST_STEP   = rlcf_pkg::DEF_FIRST_STEP
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             job_valid_i,
  output logic                                  job_take_o,
  input  wire rlcf_pkg::job_t                   job_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [rlcf_pkg::RGB_W-1:0]            red_o,
  output logic [rlcf_pkg::RGB_W-1:0]            green_o,
  output logic [rlcf_pkg::RGB_W-1:0]            blue_o,
  output logic [rlcf_pkg::STEP_OUT_W-1:0]       fade_step_o,
  output logic                                  last_o
);

  localparam int STEP_MAX = (FIRST_STEP > FADE_DIVISOR + 1) ? FIRST_STEP
                                                            : FADE_DIVISOR + 1;
  localparam int STEP_W   = $clog2(STEP_MAX + 1);
  localparam int ACC_W    = rlcf_pkg::ACC_W;
  localparam int QUOT_W   = rlcf_pkg::QUOT_W;
  localparam int RGB_W    = rlcf_pkg::RGB_W;
  localparam int NUM_CH   = rlcf_pkg::NUM_CH;

  logic                               busy_q;
  logic [STEP_W-1:0]                  step_q;
  logic [NUM_CH-1:0][ACC_W-1:0]       acc_q;
  logic [NUM_CH-1:0][ACC_W-1:0]       quot_q;
  rlcf_pkg::rgb_t                     target_q;

  logic                               out_valid_q;
  rlcf_pkg::rgb_t                     rgb_q;
  logic [rlcf_pkg::STEP_OUT_W-1:0]    step_out_q;
  logic                               last_q;

  logic                               out_ready;
  logic                               final_now;
  logic                               load;
  logic [NUM_CH-1:0][ACC_W-1:0]       quot_ext;
  logic [NUM_CH-1:0][ACC_W-1:0]       acc_init;
  rlcf_pkg::rgb_t                     clamped;

  function automatic logic [RGB_W-1:0] clamp(logic [ACC_W-1:0] v);
    logic [RGB_W-1:0] r;
    if (v[ACC_W-1]) begin
      r = '0;
    end else if (v[ACC_W-2:RGB_W] != '0) begin
      r = '1;
    end else begin
      r = v[RGB_W-1:0];
    end
    return r;
  endfunction

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign final_now  = busy_q && (step_q > STEP_W'(FADE_DIVISOR));
  // Take the next run when idle or while the exact-color beat goes out.
  assign load       = job_valid_i && (!busy_q || (out_ready && final_now));
  assign job_take_o = load;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      quot_ext[c] = {{(ACC_W - QUOT_W){job_i.quot[c][QUOT_W-1]}}, job_i.quot[c]};
      acc_init[c] = ACC_W'(job_i.start[c]) + quot_ext[c] * ACC_W'(FIRST_STEP);
      clamped[c]  = clamp(acc_q[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_q <= busy_q;
      end
      if (load) begin
        busy_q <= 1'b1;
      end else if (out_ready && final_now) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && busy_q) begin
      if (final_now) begin
        rgb_q      <= target_q;
        step_out_q <= rlcf_pkg::STEP_OUT_W'(FADE_DIVISOR + 1);
        last_q     <= 1'b1;
      end else begin
        rgb_q      <= clamped;
        step_out_q <= rlcf_pkg::STEP_OUT_W'(step_q);
        last_q     <= 1'b0;
        step_q     <= step_q + STEP_W'(1);
        for (int c = 0; c < NUM_CH; c++) begin
          acc_q[c] <= acc_q[c] + quot_q[c];
        end
      end
    end
    if (load) begin
      step_q   <= STEP_W'(FIRST_STEP);
      acc_q    <= acc_init;
      quot_q   <= quot_ext;
      target_q <= job_i.target;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = rgb_q[rlcf_pkg::CH_RED];
  assign green_o     = rgb_q[rlcf_pkg::CH_GREEN];
  assign blue_o      = rgb_q[rlcf_pkg::CH_BLUE];
  assign fade_step_o = step_out_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

### sv/rgb_led_color_fade.sv
// Channel | Signals                                   | Beat
// --------+-------------------------------------------+---------------------------------
// in      | in_valid_i, in_stall_o, event_bits_i      | one 32-bit event word
// out     | out_valid_o, out_stall_i, red_o, green_o, | one color: RGB, step, last flag
//         | blue_o, fade_step_o, last_o               |
//
// An event that changes the color yields FADE_DIVISOR - FIRST_STEP + 2 beats (12 by
// default), one per cycle from the fade engine's accumulators while out_stall_i is low;
// the next run loads while the exact-color beat leaves, so runs follow back to back.
// An event that changes nothing is dropped in the decoder and yields no beat.
// The first beat passes the event register, job register, accumulators and output register.
// Reset (rst_ni low, asynchronous) empties all stages and sets the color to black.
// A stall on the out side holds the output register and backs up into in_stall_o.
`timescale 1ns / 1ps
`default_nettype none

module rgb_led_color_fade #(
  parameter int FADE_DIVISOR = rlcf_pkg::DEF_FADE_DIVISOR,
  parameter int FIRST_STEP   = rlcf_pkg::DEF_FIRST_STEP
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [rlcf_pkg::EVENT_W-1:0]     event_bits_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [rlcf_pkg::RGB_W-1:0]            red_o,
  output logic [rlcf_pkg::RGB_W-1:0]            green_o,
  output logic [rlcf_pkg::RGB_W-1:0]            blue_o,
  output logic [rlcf_pkg::STEP_OUT_W-1:0]       fade_step_o,
  output logic                                  last_o
);

  // Decoded run waiting for the fade engine.
  logic           job_valid;
  logic           job_take;
  rlcf_pkg::job_t job;

  // Register the event, pick the target, hold the current color and
  // precompute the per-step increment of each channel.
  rlcf_decode #(
    .FADE_DIVISOR (FADE_DIVISOR)
  ) u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .event_bits_i (event_bits_i),
    .job_valid_o  (job_valid),
    .job_take_i   (job_take),
    .job_o        (job)
  );

  // Walk the fade steps by accumulation and drive the output register.
  rlcf_fade #(
    .FADE_DIVISOR (FADE_DIVISOR),
    .FIRST_STEP   (FIRST_STEP)
  ) u_fade (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_take_o  (job_take),
    .job_i       (job),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .fade_step_o (fade_step_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire
